>>> sv/qidr_pkg.sv
`default_nettype none
package qidr_pkg;

    localparam int TABLE_DEPTH = 64;

    localparam int MAP_DEPTH = 4096;
    localparam int MAP_AW    = 12;
    localparam int MAP_W     = 16;

    localparam logic [31:0] CHECK_INTERVAL_RST = 32'd60;
    localparam logic [31:0] ENTRY_TIMEOUT_RST  = 32'd600;
    localparam logic [15:0] LAST_ID_RST        = 16'hffff;

    localparam logic [1:0] KIND_QUERY = 2'd0;
    localparam logic [1:0] KIND_RESP  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic REG_CHECK_INTERVAL = 1'b0;
    localparam logic REG_ENTRY_TIMEOUT  = 1'b1;

    localparam logic [2:0] ACT_FORWARD = 3'd0;
    localparam logic [2:0] ACT_REPLY   = 3'd1;
    localparam logic [2:0] ACT_NOMATCH = 3'd2;
    localparam logic [2:0] ACT_NOROOM  = 3'd3;
    localparam logic [2:0] ACT_SKIP    = 3'd4;
    localparam logic [2:0] ACT_PURGED  = 3'd5;

    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_CLR      = 4'd1;
    localparam logic [3:0] OP_LOAD     = 4'd2;
    localparam logic [3:0] OP_SCAN_RD  = 4'd3;
    localparam logic [3:0] OP_SCAN_EV  = 4'd4;
    localparam logic [3:0] OP_HIT_WR   = 4'd5;
    localparam logic [3:0] OP_RESP_HIT = 4'd6;
    localparam logic [3:0] OP_ALLOC_RD = 4'd7;
    localparam logic [3:0] OP_ALLOC_EV = 4'd8;
    localparam logic [3:0] OP_FILL     = 4'd9;
    localparam logic [3:0] OP_NOSLOT   = 4'd10;
    localparam logic [3:0] OP_MAP_RD   = 4'd11;
    localparam logic [3:0] OP_MAP_CLR  = 4'd12;
    localparam logic [3:0] OP_OUT      = 4'd13;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] seen;
        logic [15:0] port;
        logic [15:0] new_id;
        logic [15:0] org_id;
        logic        tcp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] act;
    } t_cmd;

    typedef struct packed {
        logic       clr_last;
        logic [1:0] kind;
        logic       tick_early;
        logic       match;
        logic       scan_last;
        logic       scan_end;
        logic       alloc_found;
        logic       alloc_last;
        logic       slot_ok;
        logic       out_free;
    } t_status;

endpackage
`default_nettype wire

>>> sv/qidr_ram.sv
`default_nettype none
module qidr_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [W-1:0]  i_wdata,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> sv/qidr_ctrl.sv
`default_nettype none
module qidr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire qidr_pkg::t_status i_status,
    output qidr_pkg::t_cmd         o_cmd
);

    localparam logic [3:0] ST_CLR      = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_DISP     = 4'd2;
    localparam logic [3:0] ST_SCAN_RD  = 4'd3;
    localparam logic [3:0] ST_SCAN_EV  = 4'd4;
    localparam logic [3:0] ST_HIT_WR   = 4'd5;
    localparam logic [3:0] ST_RESP     = 4'd6;
    localparam logic [3:0] ST_ALLOC_RD = 4'd7;
    localparam logic [3:0] ST_ALLOC_EV = 4'd8;
    localparam logic [3:0] ST_FILL     = 4'd9;
    localparam logic [3:0] ST_NOSLOT   = 4'd10;
    localparam logic [3:0] ST_MAP_RD   = 4'd11;
    localparam logic [3:0] ST_MAP_CLR  = 4'd12;
    localparam logic [3:0] ST_OUT      = 4'd13;

    logic [3:0] r_state, n_state;
    logic [2:0] r_act, n_act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_act   <= qidr_pkg::ACT_NOMATCH;
        end else begin
            r_state <= n_state;
            r_act   <= n_act;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_act      = r_act;
        o_cmd.op   = qidr_pkg::OP_NONE;
        o_cmd.act  = r_act;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_CLR: begin
                o_cmd.op = qidr_pkg::OP_CLR;
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.op = qidr_pkg::OP_LOAD;
                    n_state  = ST_DISP;
                end
            end
            ST_DISP: begin
                priority if (i_status.kind == qidr_pkg::KIND_QUERY ||
                             i_status.kind == qidr_pkg::KIND_RESP) begin
                    n_state = ST_SCAN_RD;
                end else if (i_status.kind == qidr_pkg::KIND_TICK) begin
                    if (i_status.tick_early) begin
                        n_act   = qidr_pkg::ACT_SKIP;
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_SCAN_RD;
                    end
                end else begin
                    n_act   = qidr_pkg::ACT_NOMATCH;
                    n_state = ST_OUT;
                end
            end
            ST_SCAN_RD: begin
                o_cmd.op = qidr_pkg::OP_SCAN_RD;
                n_state  = ST_SCAN_EV;
            end
            ST_SCAN_EV: begin
                o_cmd.op = qidr_pkg::OP_SCAN_EV;
                if (i_status.match) begin
                    priority if (i_status.kind == qidr_pkg::KIND_QUERY) n_state = ST_HIT_WR;
                    else if (i_status.kind == qidr_pkg::KIND_RESP) n_state = ST_RESP;
                    else n_state = ST_MAP_RD;
                end else if (i_status.scan_last) begin
                    priority if (i_status.kind == qidr_pkg::KIND_QUERY) begin
                        n_state = ST_ALLOC_RD;
                    end else if (i_status.kind == qidr_pkg::KIND_RESP) begin
                        n_act   = qidr_pkg::ACT_NOMATCH;
                        n_state = ST_OUT;
                    end else begin
                        n_act   = qidr_pkg::ACT_PURGED;
                        n_state = ST_OUT;
                    end
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_HIT_WR: begin
                o_cmd.op = qidr_pkg::OP_HIT_WR;
                n_act    = qidr_pkg::ACT_FORWARD;
                n_state  = ST_OUT;
            end
            ST_RESP: begin
                o_cmd.op = qidr_pkg::OP_RESP_HIT;
                n_state  = ST_MAP_RD;
            end
            ST_ALLOC_RD: begin
                o_cmd.op = qidr_pkg::OP_ALLOC_RD;
                n_state  = ST_ALLOC_EV;
            end
            ST_ALLOC_EV: begin
                o_cmd.op = qidr_pkg::OP_ALLOC_EV;
                priority if (i_status.alloc_found) begin
                    n_state = i_status.slot_ok ? ST_FILL : ST_NOSLOT;
                end else if (i_status.alloc_last) begin
                    n_act   = qidr_pkg::ACT_NOROOM;
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_ALLOC_RD;
                end
            end
            ST_FILL: begin
                o_cmd.op = qidr_pkg::OP_FILL;
                n_act    = qidr_pkg::ACT_FORWARD;
                n_state  = ST_OUT;
            end
            ST_NOSLOT: begin
                o_cmd.op = qidr_pkg::OP_NOSLOT;
                n_act    = qidr_pkg::ACT_NOROOM;
                n_state  = ST_OUT;
            end
            ST_MAP_RD: begin
                o_cmd.op = qidr_pkg::OP_MAP_RD;
                n_state  = ST_MAP_CLR;
            end
            ST_MAP_CLR: begin
                o_cmd.op = qidr_pkg::OP_MAP_CLR;
                priority if (i_status.kind == qidr_pkg::KIND_RESP) begin
                    n_act   = qidr_pkg::ACT_REPLY;
                    n_state = ST_OUT;
                end else if (i_status.scan_end) begin
                    n_act   = qidr_pkg::ACT_PURGED;
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.op = qidr_pkg::OP_OUT;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> sv/qidr_dp.sv
`default_nettype none
module qidr_dp #(
    parameter int TABLE_DEPTH = qidr_pkg::TABLE_DEPTH,
    parameter int IW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire qidr_pkg::t_cmd    i_cmd,
    output qidr_pkg::t_status      o_status,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_addr,
    input  wire logic [31:0]       i_cfg_data,
    input  wire logic [1:0]        i_kind,
    input  wire logic [15:0]       i_msg_id,
    input  wire logic              i_proto_is_tcp,
    input  wire logic [31:0]       i_peer_addr,
    input  wire logic [15:0]       i_peer_port,
    input  wire logic [31:0]       i_now_seconds,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [2:0]             o_action,
    output logic [15:0]            o_out_id,
    output logic                   o_out_proto_is_tcp,
    output logic [31:0]            o_dest_addr,
    output logic [15:0]            o_dest_port,
    output logic [6:0]             o_purged_count
);

    localparam logic [IW-1:0] IDX_LAST = IW'(TABLE_DEPTH - 1);
    localparam logic [12:0]   K_LAST   = 13'(qidr_pkg::MAP_DEPTH);

    logic [31:0] r_interval, r_timeout, r_lpt;
    logic [15:0] r_last_id;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [qidr_pkg::MAP_AW-1:0] r_clr;
    logic        r_ovalid;

    logic [1:0]  r_kind;
    logic [15:0] r_mid, r_port;
    logic        r_tcp;
    logic [31:0] r_addr, r_now;

    logic [IW-1:0] r_idx, r_hit_idx, r_free_slot;
    logic          r_free_ok, r_hit, r_scan_end;
    logic [6:0]    r_cnt;
    qidr_pkg::t_entry r_ent;
    logic [15:0]   r_free_id;
    logic [12:0]   r_k;
    logic [15:0]   r_alloc_id;
    logic [15:0]   r_word;

    logic [2:0]  r_act;
    logic [15:0] r_oid, r_dport;
    logic        r_oproto;
    logic [31:0] r_daddr;
    logic [6:0]  r_ocnt;

    logic        map_we;
    logic [qidr_pkg::MAP_AW-1:0] map_addr;
    logic [15:0] map_wdata, map_rdata;

    logic        ent_we;
    logic [IW-1:0] ent_addr;
    qidr_pkg::t_entry ent_wdata, ent_rdata;
    logic [qidr_pkg::ENTRY_W-1:0] ent_rraw;

    logic        match, cur_valid;
    logic [15:0] start_id, lo_mask, amask, freev;
    logic [qidr_pkg::MAP_AW-1:0] aword;
    logic [3:0]  apos;
    logic        afound;
    logic        out_free;

    assign ent_rdata = qidr_pkg::t_entry'(ent_rraw);
    assign cur_valid = r_valid[r_idx];
    assign out_free  = !r_ovalid || !i_out_stall;

    always_comb begin
        match = 1'b0;
        unique case (r_kind)
            qidr_pkg::KIND_QUERY: match = ent_rdata.org_id == r_mid && ent_rdata.tcp == r_tcp
                && ent_rdata.addr == r_addr && ent_rdata.port == r_port;
            qidr_pkg::KIND_RESP:  match = ent_rdata.new_id == r_mid && ent_rdata.tcp == r_tcp;
            qidr_pkg::KIND_TICK:  match = (r_now - ent_rdata.seen) > r_timeout;
            default:              match = 1'b0;
        endcase
        match = match && cur_valid;
    end

    always_comb begin
        start_id = r_last_id + 16'd1;
        aword    = start_id[15:4] + r_k[qidr_pkg::MAP_AW-1:0];
        lo_mask  = (16'd1 << start_id[3:0]) - 16'd1;
        if (r_k == 13'd0) begin
            amask = ~lo_mask;
        end else if (r_k == K_LAST) begin
            amask = lo_mask;
        end else begin
            amask = 16'hffff;
        end
        if (aword == r_last_id[15:4]) begin
            amask = amask & ~(16'd1 << r_last_id[3:0]);
        end
        freev  = ~map_rdata & amask;
        afound = |freev;
        apos   = 4'd0;
        for (int b = 15; b >= 0; b--) begin
            if (freev[b]) apos = 4'(b);
        end
    end

    always_comb begin
        map_we    = 1'b0;
        map_addr  = r_free_id[15:4];
        map_wdata = map_rdata & ~(16'd1 << r_free_id[3:0]);
        unique case (i_cmd.op)
            qidr_pkg::OP_CLR: begin
                map_we    = 1'b1;
                map_addr  = r_clr;
                map_wdata = '0;
            end
            qidr_pkg::OP_ALLOC_RD: map_addr = aword;
            qidr_pkg::OP_FILL: begin
                map_we    = 1'b1;
                map_addr  = r_alloc_id[15:4];
                map_wdata = r_word;
            end
            qidr_pkg::OP_MAP_CLR: map_we = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        ent_we    = 1'b0;
        ent_addr  = r_idx;
        ent_wdata = r_ent;
        unique case (i_cmd.op)
            qidr_pkg::OP_HIT_WR: begin
                ent_we         = 1'b1;
                ent_addr       = r_hit_idx;
                ent_wdata.seen = r_now;
            end
            qidr_pkg::OP_FILL: begin
                ent_we           = 1'b1;
                ent_addr         = r_free_slot;
                ent_wdata.addr   = r_addr;
                ent_wdata.seen   = r_now;
                ent_wdata.port   = r_port;
                ent_wdata.new_id = r_alloc_id;
                ent_wdata.org_id = r_mid;
                ent_wdata.tcp    = r_tcp;
            end
            default: ;
        endcase
    end

    qidr_ram #(
        .W     (qidr_pkg::MAP_W),
        .DEPTH (qidr_pkg::MAP_DEPTH),
        .AW    (qidr_pkg::MAP_AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_addr  (map_addr),
        .i_wdata (map_wdata),
        .o_rdata (map_rdata)
    );

    qidr_ram #(
        .W     (qidr_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (IW)
    ) u_ent (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_addr  (ent_addr),
        .i_wdata (ent_wdata),
        .o_rdata (ent_rraw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= qidr_pkg::CHECK_INTERVAL_RST;
            r_timeout  <= qidr_pkg::ENTRY_TIMEOUT_RST;
            r_lpt      <= '0;
            r_last_id  <= qidr_pkg::LAST_ID_RST;
            r_valid    <= '0;
            r_clr      <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    qidr_pkg::REG_CHECK_INTERVAL: r_interval <= i_cfg_data;
                    qidr_pkg::REG_ENTRY_TIMEOUT:  r_timeout  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovalid && !i_out_stall) r_ovalid <= 1'b0;
            unique case (i_cmd.op)
                qidr_pkg::OP_CLR: r_clr <= r_clr + 1'b1;
                qidr_pkg::OP_SCAN_EV: begin
                    if (match && r_kind == qidr_pkg::KIND_TICK) r_valid[r_idx] <= 1'b0;
                end
                qidr_pkg::OP_RESP_HIT: r_valid[r_hit_idx] <= 1'b0;
                qidr_pkg::OP_FILL: begin
                    r_valid[r_free_slot] <= 1'b1;
                    r_last_id            <= r_alloc_id;
                end
                qidr_pkg::OP_NOSLOT: r_last_id <= r_alloc_id;
                qidr_pkg::OP_OUT: begin
                    r_ovalid <= 1'b1;
                    if (i_cmd.act == qidr_pkg::ACT_PURGED) r_lpt <= r_now;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            qidr_pkg::OP_LOAD: begin
                r_kind      <= i_kind;
                r_mid       <= i_msg_id;
                r_tcp       <= i_proto_is_tcp;
                r_addr      <= i_peer_addr;
                r_port      <= i_peer_port;
                r_now       <= i_now_seconds;
                r_idx       <= '0;
                r_free_ok   <= 1'b0;
                r_hit       <= 1'b0;
                r_scan_end  <= 1'b0;
                r_cnt       <= '0;
                r_k         <= '0;
            end
            qidr_pkg::OP_SCAN_EV: begin
                if (!cur_valid && !r_free_ok) begin
                    r_free_ok   <= 1'b1;
                    r_free_slot <= r_idx;
                end
                if (match) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_idx;
                    r_ent     <= ent_rdata;
                    r_free_id <= ent_rdata.new_id;
                    if (r_cnt != 7'd127) r_cnt <= r_cnt + 7'd1;
                end
                if (r_idx == IDX_LAST) r_scan_end <= 1'b1;
                if (!match || r_kind == qidr_pkg::KIND_TICK) r_idx <= r_idx + 1'b1;
            end
            qidr_pkg::OP_ALLOC_EV: begin
                r_k <= r_k + 13'd1;
                if (afound) begin
                    r_alloc_id <= {aword, apos};
                    r_word     <= map_rdata | (16'd1 << apos);
                end
            end
            qidr_pkg::OP_OUT: begin
                r_act    <= i_cmd.act;
                r_oid    <= '0;
                r_oproto <= 1'b0;
                r_daddr  <= '0;
                r_dport  <= '0;
                r_ocnt   <= '0;
                unique case (i_cmd.act)
                    qidr_pkg::ACT_FORWARD: begin
                        r_oid    <= r_hit ? r_ent.new_id : r_alloc_id;
                        r_oproto <= r_tcp;
                    end
                    qidr_pkg::ACT_REPLY: begin
                        r_oid    <= r_ent.org_id;
                        r_oproto <= r_ent.tcp;
                        r_daddr  <= r_ent.addr;
                        r_dport  <= r_ent.port;
                    end
                    qidr_pkg::ACT_PURGED: r_ocnt <= r_cnt;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign o_status.clr_last    = r_clr == qidr_pkg::MAP_AW'(qidr_pkg::MAP_DEPTH - 1);
    assign o_status.kind        = r_kind;
    assign o_status.tick_early  = (r_now - r_lpt) < r_interval;
    assign o_status.match       = match;
    assign o_status.scan_last   = r_idx == IDX_LAST;
    assign o_status.scan_end    = r_scan_end;
    assign o_status.alloc_found = afound;
    assign o_status.alloc_last  = r_k == K_LAST;
    assign o_status.slot_ok     = r_free_ok;
    assign o_status.out_free    = out_free;

    assign o_out_valid        = r_ovalid;
    assign o_action           = r_act;
    assign o_out_id           = r_oid;
    assign o_out_proto_is_tcp = r_oproto;
    assign o_dest_addr        = r_daddr;
    assign o_dest_port        = r_dport;
    assign o_purged_count     = r_ocnt;

endmodule
`default_nettype wire

>>> sv/query_id_remap_table.sv
// Channel   Handshake                 Payload
// input     i_in_valid / o_in_stall   i_kind i_msg_id i_proto_is_tcp i_peer_addr ...
// output    o_out_valid / i_out_stall o_action o_out_id o_out_proto_is_tcp o_dest_addr ...
// config    i_cfg_we                  i_cfg_addr i_cfg_data
// One transaction at a time. A full table scan reads the entry RAM slot by slot, each
// slot a read step then an evaluate step; a lookup that hits early ends the scan sooner.
// A new ID reads the map words in turn, at most 4097 of them, then a fill step stores it.
// Purging a slot adds a map read-modify-write; a response hit also clears its valid bit.
// After reset a clearing pass writes all 4096 map words, with the input stall held high.
// A finished result waits in the output register; the next transaction is taken meanwhile.
`default_nettype none
module query_id_remap_table #(
    parameter int TABLE_DEPTH = qidr_pkg::TABLE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [15:0] i_msg_id,
    input  wire logic        i_proto_is_tcp,
    input  wire logic [31:0] i_peer_addr,
    input  wire logic [15:0] i_peer_port,
    input  wire logic [31:0] i_now_seconds,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_action,
    output logic [15:0]      o_out_id,
    output logic             o_out_proto_is_tcp,
    output logic [31:0]      o_dest_addr,
    output logic [15:0]      o_dest_port,
    output logic [6:0]       o_purged_count,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [31:0] i_cfg_data
);

    qidr_pkg::t_cmd    cmd;
    qidr_pkg::t_status status;

    qidr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    qidr_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_data         (i_cfg_data),
        .i_kind             (i_kind),
        .i_msg_id           (i_msg_id),
        .i_proto_is_tcp     (i_proto_is_tcp),
        .i_peer_addr        (i_peer_addr),
        .i_peer_port        (i_peer_port),
        .i_now_seconds      (i_now_seconds),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_action           (o_action),
        .o_out_id           (o_out_id),
        .o_out_proto_is_tcp (o_out_proto_is_tcp),
        .o_dest_addr        (o_dest_addr),
        .o_dest_port        (o_dest_port),
        .o_purged_count     (o_purged_count)
    );

endmodule
`default_nettype wire

>>> sv/qidr_chk.sv
`default_nettype none
module qidr_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [2:0]  o_action,
    input wire logic [15:0] o_out_id,
    input wire logic [31:0] o_dest_addr,
    input wire logic [15:0] o_dest_port,
    input wire logic [6:0]  o_purged_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction taken while busy");

    a_drop_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_action != qidr_pkg::ACT_FORWARD && o_action != qidr_pkg::ACT_REPLY
        |-> o_out_id == 16'd0 && o_dest_addr == 32'd0 && o_dest_port == 16'd0)
        else $error("non-forwarding result carries header fields");

    a_count_only_purge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_action != qidr_pkg::ACT_PURGED |-> o_purged_count == 7'd0)
        else $error("purge count on non-purge result");

endmodule

bind query_id_remap_table qidr_chk u_qidr_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_action       (o_action),
    .o_out_id       (o_out_id),
    .o_dest_addr    (o_dest_addr),
    .o_dest_port    (o_dest_port),
    .o_purged_count (o_purged_count)
);
`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
module tb;

    localparam int NSLOT      = qidr_pkg::TABLE_DEPTH;
    localparam int CYCLE_CAP  = 2000000;
    localparam int DRAIN_WAIT = 300;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] mid;
        logic        tcp;
        logic [31:0] addr;
        logic [15:0] port;
        logic [31:0] now;
    } t_dns_msg;

    typedef struct packed {
        logic [2:0]  act;
        logic [15:0] id;
        logic        tcp;
        logic [31:0] addr;
        logic [15:0] port;
        logic [6:0]  cnt;
    } t_remap_out;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [1:0] i_kind = '0;
    logic [15:0] i_msg_id = '0;
    logic i_proto_is_tcp = 1'b0;
    logic [31:0] i_peer_addr = '0;
    logic [15:0] i_peer_port = '0;
    logic [31:0] i_now_seconds = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [2:0] o_action;
    logic [15:0] o_out_id;
    logic o_out_proto_is_tcp;
    logic [31:0] o_dest_addr;
    logic [15:0] o_dest_port;
    logic [6:0] o_purged_count;
    logic i_cfg_we = 1'b0;
    logic i_cfg_addr = 1'b0;
    logic [31:0] i_cfg_data = '0;

    query_id_remap_table dut (.*);

    always #1 i_clk = ~i_clk;

    bit          id_busy [65536];
    logic [15:0] last_id;
    bit          ent_v [NSLOT];
    bit          ent_tcp [NSLOT];
    logic [15:0] ent_org [NSLOT];
    logic [15:0] ent_new [NSLOT];
    logic [15:0] ent_port [NSLOT];
    logic [31:0] ent_addr [NSLOT];
    logic [31:0] ent_seen [NSLOT];
    logic [31:0] last_purge;
    logic [31:0] cfg_interval;
    logic [31:0] cfg_timeout;

    t_dns_msg   pending_msgs [$];
    t_remap_out expected_outs [$];
    t_dns_msg   cur_msg;
    int         gap_left = 0;
    bit         calm = 0;
    int         long_req = 0;
    int         long_done = 0;
    int         long_left = 0;
    int         stall_left = 0;
    int         mismatches = 0;
    int         checked = 0;
    int         cycles = 0;
    int         act_seen [8];
    logic [31:0] now_t = '0;

    function automatic t_remap_out remap_step(t_dns_msg r);
        t_remap_out o;
        int i;
        int slot;
        logic [15:0] cand;
        bit hit;
        bit got;
        o = '0;
        o.act = qidr_pkg::ACT_NOMATCH;
        hit = 0;
        got = 0;
        slot = -1;
        unique case (r.kind)
            qidr_pkg::KIND_QUERY: begin
                for (i = 0; i < NSLOT; i++) begin
                    if (!hit && ent_v[i] && ent_org[i] == r.mid && ent_tcp[i] == r.tcp
                        && ent_addr[i] == r.addr && ent_port[i] == r.port) begin
                        ent_seen[i] = r.now;
                        o.act = qidr_pkg::ACT_FORWARD;
                        o.id = ent_new[i];
                        o.tcp = r.tcp;
                        hit = 1;
                    end
                end
                if (!hit) begin
                    o.act = qidr_pkg::ACT_NOROOM;
                    cand = last_id + 16'd1;
                    while (cand != last_id && !got) begin
                        if (!id_busy[cand]) got = 1;
                        else cand = cand + 16'd1;
                    end
                    if (got) begin
                        id_busy[cand] = 1;
                        last_id = cand;
                        for (i = 0; i < NSLOT; i++)
                            if (slot < 0 && !ent_v[i]) slot = i;
                        if (slot >= 0) begin
                            ent_v[slot] = 1;
                            ent_tcp[slot] = r.tcp;
                            ent_org[slot] = r.mid;
                            ent_new[slot] = cand;
                            ent_port[slot] = r.port;
                            ent_addr[slot] = r.addr;
                            ent_seen[slot] = r.now;
                            o.act = qidr_pkg::ACT_FORWARD;
                            o.id = cand;
                            o.tcp = r.tcp;
                        end else begin
                            id_busy[cand] = 0;
                        end
                    end
                end
            end
            qidr_pkg::KIND_RESP: begin
                for (i = 0; i < NSLOT; i++) begin
                    if (!hit && ent_v[i] && ent_new[i] == r.mid && ent_tcp[i] == r.tcp) begin
                        o.act = qidr_pkg::ACT_REPLY;
                        o.id = ent_org[i];
                        o.tcp = ent_tcp[i];
                        o.addr = ent_addr[i];
                        o.port = ent_port[i];
                        id_busy[ent_new[i]] = 0;
                        ent_v[i] = 0;
                        hit = 1;
                    end
                end
            end
            qidr_pkg::KIND_TICK: begin
                if (32'(r.now - last_purge) < cfg_interval) begin
                    o.act = qidr_pkg::ACT_SKIP;
                end else begin
                    for (i = 0; i < NSLOT; i++) begin
                        if (ent_v[i] && 32'(r.now - ent_seen[i]) > cfg_timeout) begin
                            id_busy[ent_new[i]] = 0;
                            ent_v[i] = 0;
                            if (o.cnt < 7'd127) o.cnt = o.cnt + 7'd1;
                        end
                    end
                    last_purge = r.now;
                    o.act = qidr_pkg::ACT_PURGED;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) expected_outs.push_back(remap_step(cur_msg));
            if (!(i_in_valid && o_in_stall)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_msgs.size() > 0) begin
                    cur_msg = pending_msgs.pop_front();
                    i_kind <= cur_msg.kind;
                    i_msg_id <= cur_msg.mid;
                    i_proto_is_tcp <= cur_msg.tcp;
                    i_peer_addr <= cur_msg.addr;
                    i_peer_port <= cur_msg.port;
                    i_now_seconds <= cur_msg.now;
                    i_in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 6);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (long_left > 0) begin
            long_left <= long_left - 1;
            i_out_stall <= 1'b1;
        end else if (long_req != long_done) begin
            long_done <= long_req;
            long_left <= 400;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 5);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_remap_out got;
        t_remap_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_action, o_out_id, o_out_proto_is_tcp, o_dest_addr, o_dest_port,
                   o_purged_count};
            if (expected_outs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction: %p", got);
            end else begin
                want = expected_outs.pop_front();
                checked++;
                act_seen[want.act]++;
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic add_msg(logic [1:0] k, logic [15:0] m, logic t, logic [31:0] a,
                           logic [15:0] p, logic [31:0] n);
        t_dns_msg x;
        x = '{kind: k, mid: m, tcp: t, addr: a, port: p, now: n};
        pending_msgs.push_back(x);
    endtask

    task automatic cfg_write(logic idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        cfg_interval = (idx == qidr_pkg::REG_CHECK_INTERVAL) ? val : cfg_interval;
        cfg_timeout = (idx == qidr_pkg::REG_ENTRY_TIMEOUT) ? val : cfg_timeout;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_msgs.size() > 0 || i_in_valid || expected_outs.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic int pick_slot();
        int s;
        int i;
        s = $urandom_range(0, NSLOT - 1);
        for (i = 0; i < NSLOT; i++)
            if (ent_v[(s + i) % NSLOT]) return (s + i) % NSLOT;
        return -1;
    endfunction

    task automatic random_phase(int n, int qpct, int rpct, bit hold_mid, bit pause_mid);
        int j;
        int roll;
        int s;
        t_dns_msg x;
        for (j = 0; j < n; j++) begin
            while (pending_msgs.size() >= 2) @(posedge i_clk);
            if (hold_mid && j == n / 3) long_req++;
            if (pause_mid && j == n / 2) wait_idle();
            if ($urandom_range(0, 49) == 0) now_t = $urandom;
            else now_t = now_t + $urandom_range(0, 40);
            x.now = now_t;
            x.mid = 16'($urandom);
            x.tcp = 1'($urandom);
            x.addr = $urandom;
            x.port = 16'($urandom);
            roll = $urandom_range(0, 99);
            s = pick_slot();
            if (roll < qpct) begin
                x.kind = qidr_pkg::KIND_QUERY;
                if (s >= 0 && $urandom_range(0, 9) < 4) begin
                    x.mid = ent_org[s];
                    x.tcp = ent_tcp[s];
                    x.addr = ent_addr[s];
                    x.port = ent_port[s];
                end
            end else if (roll < qpct + rpct) begin
                x.kind = qidr_pkg::KIND_RESP;
                if (s >= 0 && $urandom_range(0, 9) < 8) begin
                    x.mid = ent_new[s];
                    x.tcp = ent_tcp[s];
                end
            end else if (roll < 96) begin
                x.kind = qidr_pkg::KIND_TICK;
            end else begin
                x.kind = 2'd3;
            end
            pending_msgs.push_back(x);
        end
    endtask

    initial begin
        for (int i = 0; i < NSLOT; i++) ent_v[i] = 0;
        last_id = qidr_pkg::LAST_ID_RST;
        last_purge = '0;
        cfg_interval = qidr_pkg::CHECK_INTERVAL_RST;
        cfg_timeout = qidr_pkg::ENTRY_TIMEOUT_RST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_msg(qidr_pkg::KIND_QUERY, 16'h0000, 1'b0, 32'h0, 16'h0, 32'd0);
        add_msg(qidr_pkg::KIND_QUERY, 16'hffff, 1'b1, 32'hffffffff, 16'hffff, 32'd1);
        add_msg(qidr_pkg::KIND_QUERY, 16'h0000, 1'b0, 32'h0, 16'h0, 32'd2);
        add_msg(qidr_pkg::KIND_QUERY, 16'h0000, 1'b1, 32'h0, 16'h0, 32'd3);
        add_msg(qidr_pkg::KIND_RESP, 16'h0000, 1'b0, 32'h0, 16'h0, 32'd4);
        add_msg(qidr_pkg::KIND_RESP, 16'h0000, 1'b0, 32'h0, 16'h0, 32'd5);
        add_msg(qidr_pkg::KIND_RESP, 16'h0001, 1'b0, 32'h0, 16'h0, 32'd6);
        add_msg(qidr_pkg::KIND_RESP, 16'h0001, 1'b1, 32'h5, 16'h7, 32'd7);
        add_msg(qidr_pkg::KIND_QUERY, 16'h1234, 1'b0, 32'h0a000001, 16'd53, 32'd8);
        add_msg(qidr_pkg::KIND_TICK, 16'h0, 1'b0, 32'h0, 16'h0, 32'd10);
        add_msg(qidr_pkg::KIND_TICK, 16'h0, 1'b0, 32'h0, 16'h0, 32'd60);
        add_msg(qidr_pkg::KIND_TICK, 16'h0, 1'b0, 32'h0, 16'h0, 32'd2000);
        add_msg(qidr_pkg::KIND_TICK, 16'h0, 1'b0, 32'h0, 16'h0, 32'd2001);
        add_msg(qidr_pkg::KIND_RESP, 16'h0002, 1'b1, 32'h0, 16'h0, 32'd2002);
        add_msg(2'd3, 16'hffff, 1'b1, 32'hffffffff, 16'hffff, 32'hffffffff);
        add_msg(qidr_pkg::KIND_QUERY, 16'h8000, 1'b1, 32'h80000000, 16'h8000, 32'hffffffff);
        add_msg(qidr_pkg::KIND_TICK, 16'h0, 1'b0, 32'h0, 16'h0, 32'd100);
        now_t = 32'd100;
        wait_idle();

        cfg_write(qidr_pkg::REG_CHECK_INTERVAL, 32'd60);
        cfg_write(qidr_pkg::REG_ENTRY_TIMEOUT, 32'd600);
        random_phase(140, 45, 35, 1, 0);
        wait_idle();
        cfg_write(qidr_pkg::REG_CHECK_INTERVAL, 32'd0);
        cfg_write(qidr_pkg::REG_ENTRY_TIMEOUT, 32'hffffffff);
        random_phase(200, 70, 10, 0, 1);
        wait_idle();
        cfg_write(qidr_pkg::REG_CHECK_INTERVAL, 32'hffffffff);
        cfg_write(qidr_pkg::REG_ENTRY_TIMEOUT, 32'd300);
        random_phase(120, 45, 35, 0, 0);
        wait_idle();
        cfg_write(qidr_pkg::REG_CHECK_INTERVAL, 32'd0);
        cfg_write(qidr_pkg::REG_ENTRY_TIMEOUT, 32'd0);
        random_phase(120, 45, 30, 0, 0);
        wait_idle();
        cfg_write(qidr_pkg::REG_CHECK_INTERVAL, 32'd5);
        cfg_write(qidr_pkg::REG_ENTRY_TIMEOUT, 32'd40);
        random_phase(60, 45, 35, 0, 0);
        calm = 1;
        random_phase(60, 45, 35, 0, 0);
        wait_idle();

        $display("checked %0d transactions over five register settings", checked);
        $display("forward %0d reply %0d nomatch %0d noroom %0d skip %0d purge %0d",
                 act_seen[qidr_pkg::ACT_FORWARD], act_seen[qidr_pkg::ACT_REPLY],
                 act_seen[qidr_pkg::ACT_NOMATCH], act_seen[qidr_pkg::ACT_NOROOM],
                 act_seen[qidr_pkg::ACT_SKIP], act_seen[qidr_pkg::ACT_PURGED]);
        if (mismatches == 0 && expected_outs.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
